[rtl/bsr_pkg.sv]
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared widths and input mode codes for the byte stream reassembler.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned INDEX_W = 32;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LIMIT_W = 6;
  localparam int unsigned COUNT_W = 6;

  // window limit after reset
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  // input modes
  localparam logic [MODE_W-1:0] MODE_DATA   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINAL  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

endpackage

[rtl/bsr_ram.sv]
// ----------------------------------------------------------------------------
// bsr_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/byte_stream_reassembler.sv]
// ----------------------------------------------------------------------------
// byte_stream_reassembler
// Reorders indexed stream bytes through a receive window held in a RAM.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Every command
// produces one or more results, each shown for exactly one cycle with
// res_strobe_o; the receiver cannot stall them. A data byte that lands out of
// order, is dropped, or is ignored is first registered, then evaluated and,
// if it lands in the window, written to the window RAM. An in-order byte that
// releases n stored bytes is followed by a drain that reads the window RAM
// one slot per cycle and emits one result per cycle. An end mark or final byte
// adds a sweep over the valid bits to discard bytes beyond the new end.
// A command after the stream has ended, or with the unused mode, answers with
// a status result in the cycle after acceptance and leaves the block idle. The window
// limit register may be written only while the block is idle.
// ----------------------------------------------------------------------------
module byte_stream_reassembler #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // command channel
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [bsr_pkg::MODE_W-1:0]  mode_i,
  input  logic [bsr_pkg::INDEX_W-1:0] byte_index_i,
  input  logic [bsr_pkg::BYTE_W-1:0]  data_byte_i,
  // configuration channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [bsr_pkg::LIMIT_W-1:0] cfg_data_i,
  // result channel
  output logic                        res_strobe_o,
  output logic                        out_valid_o,
  output logic [bsr_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        run_last_o,
  output logic                        stream_ended_o,
  output logic [bsr_pkg::COUNT_W-1:0] held_count_o
);

  localparam int unsigned SW  = $clog2(CAPACITY);
  localparam int unsigned SWP = SW + 1;
  localparam int unsigned EW  = $clog2(CAPACITY + 1);
  localparam int unsigned IW  = bsr_pkg::INDEX_W;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PURGE = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  // slot arithmetic modulo the capacity
  function automatic logic [SW-1:0] slot_add(input logic [SW-1:0] a,
                                             input logic [SW-1:0] b);
    logic [SWP-1:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SWP'(CAPACITY)) begin
      s = s - SWP'(CAPACITY);
    end
    return s[SW-1:0];
  endfunction

  logic [1:0]                   state_q, state_d;
  logic [bsr_pkg::MODE_W-1:0]   mode_q;
  logic [IW-1:0]                idx_q;
  logic [bsr_pkg::BYTE_W-1:0]   byte_q;
  logic [bsr_pkg::LIMIT_W-1:0]  limit_q;
  logic [IW-1:0]                next_q, next_d;
  logic [SW-1:0]                next_slot_q, next_slot_d;
  logic [IW-1:0]                end_off_q, end_off_d;
  logic                         end_known_q, end_known_d;
  logic                         ended_q, ended_d;
  logic [SW-1:0]                pending_q, pending_d;
  logic [CAPACITY-1:0]          valid_q, valid_d;
  logic [SW-1:0]                purge_cnt_q, purge_cnt_d;
  logic [SW-1:0]                purge_slot_q, purge_slot_d;
  logic                         res_strobe_q, res_strobe_d;
  logic                         out_valid_q, out_valid_d;
  logic [bsr_pkg::BYTE_W-1:0]   out_byte_q, out_byte_d;
  logic                         run_last_q, run_last_d;

  logic                         item_take;
  logic [IW-1:0]                ahead;
  logic                         past_end;
  logic [EW-1:0]                eff_limit;
  logic                         in_window;
  logic                         is_data;
  logic [SW-1:0]                store_slot;
  logic [SW-1:0]                follow_slot;
  logic                         purge_hit;
  logic                         ended_after_step;
  logic                         run_more;
  logic                         ram_we;
  logic [bsr_pkg::BYTE_W-1:0]   ram_rdata;

  assign item_take   = start_i && !busy_o;
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // window offsets of the held command
  assign ahead    = idx_q - next_q;
  assign past_end = end_known_q && (ahead >= end_off_q);
  assign is_data  = (mode_q == bsr_pkg::MODE_DATA) || (mode_q == bsr_pkg::MODE_FINAL);

  // limit zero acts as one, limit above capacity saturates
  always_comb begin
    if (limit_q == '0) begin
      eff_limit = EW'(1);
    end else if (32'(limit_q) > CAPACITY) begin
      eff_limit = EW'(CAPACITY);
    end else begin
      eff_limit = EW'(limit_q);
    end
  end

  assign in_window   = ahead < IW'(eff_limit);
  assign store_slot  = slot_add(next_slot_q, ahead[SW-1:0]);
  assign follow_slot = slot_add(next_slot_q, SW'(1));
  assign purge_hit   = valid_q[purge_slot_q] && (IW'(purge_cnt_q) >= end_off_q);

  // delivering one byte reaches the end when one byte was left
  assign ended_after_step = end_known_q && (end_off_q == IW'(1));
  assign run_more         = !ended_after_step && valid_q[follow_slot];

  // window byte storage
  bsr_ram #(
    .WIDTH (bsr_pkg::BYTE_W),
    .DEPTH (CAPACITY)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (store_slot),
    .wdata_i (byte_q),
    .raddr_i (follow_slot),
    .rdata_o (ram_rdata)
  );

  // sequencer and state update
  always_comb begin
    state_d      = state_q;
    next_d       = next_q;
    next_slot_d  = next_slot_q;
    end_off_d    = end_off_q;
    end_known_d  = end_known_q;
    ended_d      = ended_q;
    pending_d    = pending_q;
    valid_d      = valid_q;
    purge_cnt_d  = purge_cnt_q;
    purge_slot_d = purge_slot_q;
    res_strobe_d = 1'b0;
    out_valid_d  = 1'b0;
    out_byte_d   = '0;
    run_last_d   = 1'b1;
    ram_we       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (item_take) begin
          if (ended_q || (mode_i == bsr_pkg::MODE_UNUSED)) begin
            // ignored command: status transfer only
            res_strobe_d = 1'b1;
          end else if ((mode_i == bsr_pkg::MODE_END) || (mode_i == bsr_pkg::MODE_FINAL)) begin
            // record the end as an offset from the next expected index
            end_off_d    = byte_index_i - next_q
                           + IW'(mode_i == bsr_pkg::MODE_FINAL);
            end_known_d  = 1'b1;
            purge_cnt_d  = SW'(1);
            purge_slot_d = follow_slot;
            state_d      = S_PURGE;
          end else begin
            state_d = S_EVAL;
          end
        end
      end

      S_PURGE: begin
        // drop stored bytes at or beyond the new end, one slot per cycle
        if (purge_hit) begin
          valid_d[purge_slot_q] = 1'b0;
          pending_d             = pending_q - SW'(1);
        end
        if (purge_cnt_q == SW'(CAPACITY - 1)) begin
          state_d = S_EVAL;
        end else begin
          purge_cnt_d  = purge_cnt_q + SW'(1);
          purge_slot_d = slot_add(purge_slot_q, SW'(1));
        end
      end

      S_EVAL: begin
        res_strobe_d = 1'b1;
        if (is_data && !past_end && (ahead == '0)) begin
          // in-order byte goes straight out
          out_valid_d = 1'b1;
          out_byte_d  = byte_q;
          next_d      = next_q + IW'(1);
          next_slot_d = follow_slot;
          end_off_d   = end_off_q - IW'(1);
          ended_d     = ended_after_step;
          run_last_d  = !run_more;
          state_d     = run_more ? S_DRAIN : S_IDLE;
        end else begin
          // store inside the window, otherwise status only
          if (is_data && !past_end && in_window) begin
            ram_we = 1'b1;
            if (!valid_q[store_slot]) begin
              valid_d[store_slot] = 1'b1;
              pending_d           = pending_q + SW'(1);
            end
          end
          ended_d = end_known_q && (end_off_q == '0);
          state_d = S_IDLE;
        end
      end

      S_DRAIN: begin
        // deliver the stored run, one slot per cycle
        res_strobe_d         = 1'b1;
        out_valid_d          = 1'b1;
        out_byte_d           = ram_rdata;
        valid_d[next_slot_q] = 1'b0;
        pending_d            = pending_q - SW'(1);
        next_d               = next_q + IW'(1);
        next_slot_d          = follow_slot;
        end_off_d            = end_off_q - IW'(1);
        ended_d              = ended_after_step;
        run_last_d           = !run_more;
        state_d              = run_more ? S_DRAIN : S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      next_q       <= '0;
      next_slot_q  <= '0;
      end_off_q    <= '0;
      end_known_q  <= 1'b0;
      ended_q      <= 1'b0;
      pending_q    <= '0;
      valid_q      <= '0;
      purge_cnt_q  <= '0;
      purge_slot_q <= '0;
      res_strobe_q <= 1'b0;
      limit_q      <= bsr_pkg::LIMIT_RESET;
    end else begin
      state_q      <= state_d;
      next_q       <= next_d;
      next_slot_q  <= next_slot_d;
      end_off_q    <= end_off_d;
      end_known_q  <= end_known_d;
      ended_q      <= ended_d;
      pending_q    <= pending_d;
      valid_q      <= valid_d;
      purge_cnt_q  <= purge_cnt_d;
      purge_slot_q <= purge_slot_d;
      res_strobe_q <= res_strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  // command and result payload
  always_ff @(posedge clk_i) begin
    if (item_take) begin
      mode_q <= mode_i;
      idx_q  <= byte_index_i;
      byte_q <= data_byte_i;
    end
    out_valid_q <= out_valid_d;
    out_byte_q  <= out_byte_d;
    run_last_q  <= run_last_d;
  end

  assign res_strobe_o   = res_strobe_q;
  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign run_last_o     = run_last_q;
  assign stream_ended_o = ended_q;
  assign held_count_o   = bsr_pkg::COUNT_W'(pending_q);

endmodule

[tb/tb_byte_stream_reassembler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_reassembler
// Self-checking bench for the byte stream reassembler: indexed bytes, end
// marks and noise go in through the command port, and every strobed result is
// checked against a cycle-free prediction of the receive window.
// ----------------------------------------------------------------------------

// one strobed result as seen on the result ports
typedef struct {
  logic       valid;
  logic [7:0] data;
  logic       last;
  logic       ended;
  logic [5:0] held;
} delivery_t;

// receive window prediction and the in-order results still owed by the block
class delivery_board;
  localparam int unsigned SLOTS = 32;

  logic [7:0]  slot_byte[SLOTS];
  logic        slot_held[SLOTS];
  logic [31:0] next_pos;
  logic [31:0] end_pos;
  logic        end_seen;
  int          held;
  logic        finished;
  logic [5:0]  limit;
  delivery_t   due[$];
  int          mismatches;

  function new();
    foreach (slot_held[i]) slot_held[i] = 1'b0;
    next_pos   = '0;
    end_pos    = '0;
    end_seen   = 1'b0;
    held       = 0;
    finished   = 1'b0;
    limit      = bsr_pkg::LIMIT_RESET;
    mismatches = 0;
  endfunction

  // bytes ahead of the next position that may be taken, zero acts as one
  function int window_span();
    int span;
    span = int'(limit);
    if (span < 1) span = 1;
    if (span > int'(SLOTS)) span = int'(SLOTS);
    return span;
  endfunction

  function void settle_end();
    if (end_seen && next_pos == end_pos) finished = 1'b1;
  endfunction

  function void queue_delivery(logic valid, logic [7:0] value);
    delivery_t d;
    d.valid = valid;
    d.data  = value;
    d.last  = 1'b0;
    d.ended = finished;
    d.held  = 6'(held);
    due.push_back(d);
  endfunction

  // note an accepted command and work out what it will deliver
  function void take_command(logic [1:0] mode, logic [31:0] idx, logic [7:0] value);
    logic [31:0] ahead;
    logic [31:0] end_off;
    logic [31:0] pos;
    int          first;
    int          step;
    int          s;
    delivery_t   tail;
    first = due.size();
    if (!finished && mode != bsr_pkg::MODE_UNUSED) begin
      if (mode == bsr_pkg::MODE_END || mode == bsr_pkg::MODE_FINAL) begin
        end_pos  = (mode == bsr_pkg::MODE_FINAL) ? idx + 32'd1 : idx;
        end_seen = 1'b1;
        end_off  = end_pos - next_pos;
        // stored bytes at or beyond the new end are thrown away
        for (step = 1; step < int'(SLOTS); step++) begin
          pos = next_pos + 32'(step);
          s   = int'(pos % SLOTS);
          if (slot_held[s] && 32'(step) >= end_off) begin
            slot_held[s] = 1'b0;
            if (held > 0) held--;
          end
        end
      end
      if (mode == bsr_pkg::MODE_DATA || mode == bsr_pkg::MODE_FINAL) begin
        ahead = idx - next_pos;
        if (!(end_seen && ahead >= end_pos - next_pos)) begin
          if (ahead == 32'd0) begin
            // in-order byte, then drain the contiguous stored run
            next_pos++;
            settle_end();
            queue_delivery(1'b1, value);
            step = 0;
            while (step < int'(SLOTS) && !finished) begin
              s = int'(next_pos % SLOTS);
              if (!slot_held[s]) break;
              slot_held[s] = 1'b0;
              if (held > 0) held--;
              next_pos++;
              settle_end();
              queue_delivery(1'b1, slot_byte[s]);
              step++;
            end
          end else if (ahead < 32'(window_span())) begin
            s = int'(idx % SLOTS);
            if (!slot_held[s]) begin
              slot_held[s] = 1'b1;
              held++;
            end
            slot_byte[s] = value;
          end
        end
      end
      settle_end();
    end
    if (due.size() == first) queue_delivery(1'b0, 8'd0);
    tail = due.pop_back();
    tail.last = 1'b1;
    due.push_back(tail);
  endfunction

  task report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task compare_field(string name, int got, int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // check one strobed result against the oldest owed delivery
  task check_delivery(delivery_t got);
    delivery_t want;
    if (due.size() == 0) begin
      report_mismatch($sformatf("result with nothing owed, byte %02h", got.data));
    end else begin
      want = due.pop_front();
      compare_field("out_valid",    int'(got.valid), int'(want.valid));
      compare_field("out_byte",     int'(got.data),  int'(want.data));
      compare_field("run_last",     int'(got.last),  int'(want.last));
      compare_field("stream_ended", int'(got.ended), int'(want.ended));
      compare_field("held_count",   int'(got.held),  int'(want.held));
    end
  endtask
endclass

module tb_byte_stream_reassembler;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 65;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                start_i = 1'b0;
  logic                                busy_o;
  logic [bsr_pkg::MODE_W-1:0]          mode_i = bsr_pkg::MODE_DATA;
  logic [bsr_pkg::INDEX_W-1:0]         byte_index_i = '0;
  logic [bsr_pkg::BYTE_W-1:0]          data_byte_i = '0;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [bsr_pkg::LIMIT_W-1:0]         cfg_data_i = '0;
  logic                                res_strobe_o;
  logic                                out_valid_o;
  logic [bsr_pkg::BYTE_W-1:0]          out_byte_o;
  logic                                run_last_o;
  logic                                stream_ended_o;
  logic [bsr_pkg::COUNT_W-1:0]         held_count_o;

  delivery_board board = new();
  int unsigned   cycle_count = 0;
  int            burst_left = 0;
  int            useful_items = 0;

  byte_stream_reassembler #(
    .CAPACITY(SLOTS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .byte_index_i  (byte_index_i),
    .data_byte_i   (data_byte_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .res_strobe_o  (res_strobe_o),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .stream_ended_o(stream_ended_o),
    .held_count_o  (held_count_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // result monitor
  always @(posedge clk_i) begin
    delivery_t got;
    if (rst_ni && res_strobe_o) begin
      got.valid = out_valid_o;
      got.data  = out_byte_o;
      got.last  = run_last_o;
      got.ended = stream_ended_o;
      got.held  = held_count_o;
      board.check_delivery(got);
    end
  end

  // sender bursts with random gaps, some long stretches without a gap
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  // one command transfer
  task automatic send_command(input logic [1:0] mode, input logic [31:0] idx,
                              input logic [7:0] value);
    pace();
    start_i      <= 1'b1;
    mode_i       <= mode;
    byte_index_i <= idx;
    data_byte_i  <= value;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.take_command(mode, idx, value);
    if (mode != bsr_pkg::MODE_UNUSED) useful_items++;
  endtask

  // wait until every owed result is in and the block is idle
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (board.due.size() != 0 || busy_o) @(posedge clk_i);
  endtask

  // window limit write, only while idle
  task automatic write_limit(input logic [5:0] value);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.limit = value;
  endtask

  // end mark well beyond anything the run will deliver
  task automatic send_far_end();
    logic [31:0] idx;
    idx = board.next_pos + 32'd2000 + 32'($urandom_range(0, 60000));
    if ($urandom_range(0, 1) == 0) begin
      send_command(bsr_pkg::MODE_END, idx, 8'($urandom_range(0, 255)));
    end else begin
      send_command(bsr_pkg::MODE_FINAL, idx, 8'($urandom_range(0, 255)));
    end
  endtask

  // end mark inside the window to purge stored bytes, then moved away again
  task automatic send_near_end();
    logic [31:0] idx;
    idx = board.next_pos + 32'($urandom_range(1, board.window_span()));
    if ($urandom_range(0, 1) == 0) begin
      send_command(bsr_pkg::MODE_END, idx, 8'($urandom_range(0, 255)));
    end else begin
      send_command(bsr_pkg::MODE_FINAL, idx, 8'($urandom_range(0, 255)));
    end
    send_far_end();
  endtask

  // stale, far, wild or unused commands
  task automatic send_noise();
    logic [31:0] idx;
    case ($urandom_range(0, 4))
      0: send_command(bsr_pkg::MODE_DATA, board.next_pos - 32'($urandom_range(1, 300)),
                      8'($urandom_range(0, 255)));
      1: send_command(bsr_pkg::MODE_DATA,
                      board.next_pos + 32'(board.window_span() + $urandom_range(0, 100)),
                      8'($urandom_range(0, 255)));
      2: send_command(bsr_pkg::MODE_DATA, $urandom(), 8'($urandom_range(0, 255)));
      3: send_command(bsr_pkg::MODE_UNUSED, $urandom(), 8'($urandom_range(0, 255)));
      default: begin
        // keep a wild end mark clear of the delivery point
        idx = $urandom();
        if (idx - board.next_pos < 32'd70000) idx = idx ^ 32'h8000_0000;
        send_command(($urandom_range(0, 1) == 0) ? bsr_pkg::MODE_END : bsr_pkg::MODE_FINAL,
                     idx, 8'($urandom_range(0, 255)));
        send_far_end();
      end
    endcase
  endtask

  // a run of bytes from the delivery point, shuffled, with repeats and noise
  task automatic send_segment(input int len);
    int          order[$];
    int          sent[$];
    int          j;
    int          k;
    int          tmp;
    logic [31:0] base;
    base = board.next_pos;
    for (j = 0; j < len; j++) order.push_back(j);
    for (j = len - 1; j > 0; j--) begin
      k = $urandom_range(0, j);
      tmp = order[j];
      order[j] = order[k];
      order[k] = tmp;
    end
    for (j = 0; j < len; j++) begin
      if ($urandom_range(0, 7) == 0) send_noise();
      if ($urandom_range(0, 15) == 0) send_near_end();
      send_command(bsr_pkg::MODE_DATA, base + 32'(order[j]), 8'($urandom_range(0, 255)));
      sent.push_back(order[j]);
      if ($urandom_range(0, 7) == 0) begin
        k = sent[$urandom_range(0, sent.size() - 1)];
        send_command(bsr_pkg::MODE_DATA, base + 32'(k), 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // stimulus
  initial begin
    logic [5:0]  phase_limit[6];
    logic [31:0] base;
    int          target;
    int          span;
    int          p;

    phase_limit = '{6'd63, 6'd1, 6'd9, 6'd0, 6'd32, 6'd0};
    phase_limit[3] = 6'($urandom_range(2, 31));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reorder, repeats, drops and unused mode
    send_command(bsr_pkg::MODE_DATA, 32'd0, 8'h00);
    send_command(bsr_pkg::MODE_DATA, 32'd3, 8'hFF);
    send_command(bsr_pkg::MODE_DATA, 32'd3, 8'hA5);
    send_command(bsr_pkg::MODE_DATA, 32'd2, 8'h3C);
    send_command(bsr_pkg::MODE_DATA, 32'd1, 8'h5A);
    send_command(bsr_pkg::MODE_DATA, 32'd0, 8'h77);
    send_command(bsr_pkg::MODE_DATA, 32'hFFFF_FFFF, 8'hFF);
    send_command(bsr_pkg::MODE_DATA, 32'd35, 8'h81);
    send_command(bsr_pkg::MODE_DATA, 32'd36, 8'h7E);
    send_command(bsr_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 8'hFF);
    // end marks: purge, bytes past the end, end behind delivery, wrapped end
    send_command(bsr_pkg::MODE_END, 32'd24, 8'h00);
    send_command(bsr_pkg::MODE_DATA, 32'd29, 8'h42);
    send_command(bsr_pkg::MODE_END, 32'd0, 8'hFF);
    send_command(bsr_pkg::MODE_DATA, 32'd9, 8'h99);
    send_command(bsr_pkg::MODE_FINAL, 32'hFFFF_FFFF, 8'h00);
    send_far_end();
    // limit lowered under a stored byte, then zero, then saturating
    write_limit(6'd3);
    send_command(bsr_pkg::MODE_DATA, 32'd5, 8'h55);
    send_command(bsr_pkg::MODE_DATA, 32'd6, 8'h66);
    send_command(bsr_pkg::MODE_DATA, 32'd4, 8'h44);
    send_command(bsr_pkg::MODE_DATA, 32'd7, 8'h07);
    send_command(bsr_pkg::MODE_DATA, 32'd8, 8'h08);
    write_limit(6'd0);
    send_command(bsr_pkg::MODE_DATA, 32'd11, 8'hEE);
    send_command(bsr_pkg::MODE_DATA, 32'd10, 8'h10);
    write_limit(6'd63);
    send_command(bsr_pkg::MODE_DATA, 32'd42, 8'hC3);
    send_command(bsr_pkg::MODE_DATA, 32'd43, 8'h3C);
    send_command(bsr_pkg::MODE_FINAL, 32'd21, 8'h21);
    send_far_end();

    // random phases, one window limit each
    target = useful_items;
    for (p = 0; p < 6; p++) begin
      write_limit(phase_limit[p]);
      target += PHASE_ITEMS;
      while (useful_items < target) begin
        span = board.window_span();
        send_segment(($urandom_range(0, 5) == 0) ? span : $urandom_range(1, span));
      end
    end

    // close the stream with a final byte, then poke it after the end
    write_limit(bsr_pkg::LIMIT_RESET);
    base = board.next_pos;
    send_command(bsr_pkg::MODE_DATA, base + 32'd2, 8'($urandom_range(0, 255)));
    send_command(bsr_pkg::MODE_FINAL, base + 32'd3, 8'($urandom_range(0, 255)));
    send_command(bsr_pkg::MODE_DATA, base + 32'd1, 8'($urandom_range(0, 255)));
    send_command(bsr_pkg::MODE_DATA, base, 8'($urandom_range(0, 255)));
    send_command(bsr_pkg::MODE_DATA, board.next_pos, 8'hFF);
    send_command(bsr_pkg::MODE_END, board.next_pos + 32'd5, 8'h00);
    send_command(bsr_pkg::MODE_UNUSED, 32'd0, 8'h00);

    // drain and let any stray result show up
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bsr_pkg.sv
rtl/bsr_ram.sv
rtl/byte_stream_reassembler.sv
tb/tb_byte_stream_reassembler.sv
